### sv/tep_pkg.sv
// types and constants shared by the threshold event picker
// no dependencies
`timescale 1ns / 1ps

package tep_pkg;

	localparam int CHAN_W    = 3;
	localparam int FRAME_W   = 48;
	localparam int LEVEL_W   = 32;
	localparam int REG_W     = 32;
	localparam int PADDR_W   = 4;
	localparam int REG_IDX_W = 2;

	// register indexes, byte address is 4 * index
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MIN_LENGTH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_LENGTH = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_REFRACTORY = 2'd3;

	localparam logic signed [REG_W-1:0] THRESHOLD_RST  = 32'sd65536;
	localparam logic [REG_W-1:0]        MIN_LENGTH_RST = 32'd0;
	// all ones in max_length turns the length cap off
	localparam logic [REG_W-1:0]        CAP_OFF        = 32'hFFFF_FFFF;
	localparam logic [REG_W-1:0]        REFRACTORY_RST = 32'd0;
	localparam logic [REG_W-1:0]        COUNT_MAX      = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [CHAN_W-1:0]         chan_id;
		logic [FRAME_W-1:0]        frame_sample;
		logic signed [LEVEL_W-1:0] level;
	} tep_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0]         event_chan;
		logic [FRAME_W-1:0]        event_start;
		logic [FRAME_W-1:0]        event_duration;
		logic [FRAME_W-1:0]        event_peak_time;
		logic signed [LEVEL_W-1:0] event_peak;
	} tep_out_t;

endpackage

### sv/threshold_event_picker.sv
// threshold event picker: per-channel run tracking, length limits and gap gate
// depends on tep_pkg
`timescale 1ns / 1ps

// channel   signals                                      direction
// in        in_valid, in_ready, in_data (tep_in_t)       word in
// out       out_valid, out_ready, out_data (tep_out_t)   word out
// config    psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// an accepted word sits in the input stage, where the channel state is
// read, updated and written back, and any event lands in the output register
// one word per cycle sustained while the output register is free or taken; out_valid
// rises at the edge where the input stage advances a word that produces an event
// reset clears all channel state and loads the register defaults
// a full output register that is not taken holds the input stage; one more word
// is still accepted into an empty input stage
module threshold_event_picker #(
	parameter int NUM_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  tep_pkg::tep_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output tep_pkg::tep_out_t            out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tep_pkg::PADDR_W-1:0]  paddr,
	input  logic [tep_pkg::REG_W-1:0]    pwdata,
	output logic [tep_pkg::REG_W-1:0]    prdata,
	output logic                         pready
);
	import tep_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	// wide enough for signed differences of sample indexes and 32-bit limits
	localparam int DW   = (SAMPLE_BITS + 3 > 34) ? SAMPLE_BITS + 3 : 34;

	// configuration registers
	logic signed [REG_W-1:0] threshold_q;
	logic [REG_W-1:0]        min_length_q;
	logic [REG_W-1:0]        max_length_q;
	logic [REG_W-1:0]        refractory_q;
	logic [REG_IDX_W-1:0]    reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= THRESHOLD_RST;
			min_length_q <= MIN_LENGTH_RST;
			max_length_q <= CAP_OFF;
			refractory_q <= REFRACTORY_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_THRESHOLD:  threshold_q  <= pwdata;
				REG_MIN_LENGTH: min_length_q <= pwdata;
				REG_MAX_LENGTH: max_length_q <= pwdata;
				REG_REFRACTORY: refractory_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_THRESHOLD:  prdata = threshold_q;
			REG_MIN_LENGTH: prdata = min_length_q;
			REG_MAX_LENGTH: prdata = max_length_q;
			REG_REFRACTORY: prdata = refractory_q;
			default:        prdata = '0;
		endcase
	end

	// per-channel state
	logic [REG_W-1:0]        over_count_q    [NUM_CHANNELS];
	logic [REG_W-1:0]        under_count_q   [NUM_CHANNELS];
	logic [SB-1:0]           run_start_q     [NUM_CHANNELS];
	logic [SB-1:0]           run_end_q       [NUM_CHANNELS];
	logic signed [LEVEL_W-1:0] peak_value_q  [NUM_CHANNELS];
	logic [SB-1:0]           peak_time_q     [NUM_CHANNELS];
	logic [SB-1:0]           prev_start_q    [NUM_CHANNELS];
	logic                    prev_valid_q    [NUM_CHANNELS];
	logic [SB-1:0]           prev_duration_q [NUM_CHANNELS];

	// input stage and output register
	logic     v_s1;
	tep_in_t  in_s1;
	logic     out_valid_q;
	tep_out_t out_data_q;
	logic     adv;

	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// single pass over the selected channel
	logic [CH_W-1:0]           cidx;
	logic                      chan_ok;
	logic [SB-1:0]             samp;
	logic                      cap_off;
	logic                      over_hit;
	logic [REG_W-1:0]          oc, uc, uc_inc;
	logic [SB-1:0]             rs, re, pt, ps, pd;
	logic signed [LEVEL_W-1:0] pv;
	logic                      pvld;
	logic signed [DW-1:0]      dur, gap, refr;
	logic                      run_ok, gap_ok, emit;
	logic                      under_done;
	logic [SB-1:0]             dur_u;
	logic                      new_peak;

	assign cidx    = CH_W'(in_s1.chan_id);
	assign chan_ok = 32'(in_s1.chan_id) < NUM_CHANNELS;
	assign samp    = SB'(in_s1.frame_sample);
	assign cap_off = (max_length_q == CAP_OFF);

	assign oc   = over_count_q[cidx];
	assign uc   = under_count_q[cidx];
	assign rs   = run_start_q[cidx];
	assign re   = run_end_q[cidx];
	assign pv   = peak_value_q[cidx];
	assign pt   = peak_time_q[cidx];
	assign ps   = prev_start_q[cidx];
	assign pvld = prev_valid_q[cidx];
	assign pd   = prev_duration_q[cidx];

	always_comb begin
		// the cap lets two items past max_length so the run is later rejected
		over_hit = (in_s1.level > threshold_q) &&
			(cap_off || ({1'b0, oc} <= ({1'b0, max_length_q} + 33'd1)));
		new_peak = (oc == '0) || (in_s1.level >= pv);
		uc_inc   = (uc == COUNT_MAX) ? uc : uc + 32'd1;
		under_done = !(uc_inc < refractory_q);

		dur    = $signed(DW'(re)) - $signed(DW'(rs)) + DW'(1);
		run_ok = (oc != '0) && (dur >= $signed(DW'(min_length_q))) &&
			(cap_off || (oc <= max_length_q));
		dur_u  = (dur > $signed(DW'({SB{1'b1}}))) ? {SB{1'b1}} : dur[SB-1:0];

		// distance from the end of the previous accepted run, both signs
		gap    = $signed(DW'(rs)) - $signed(DW'(ps)) - $signed(DW'(pd));
		refr   = $signed(DW'(refractory_q));
		gap_ok = (gap >= refr) || (gap <= -refr);
		emit   = !pvld || (rs < ps) || gap_ok;
	end

	logic load_out;
	assign load_out = adv && chan_ok && !over_hit && under_done && run_ok && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				over_count_q[c]    <= '0;
				under_count_q[c]   <= '0;
				run_start_q[c]     <= '0;
				run_end_q[c]       <= '0;
				peak_value_q[c]    <= '0;
				peak_time_q[c]     <= '0;
				prev_start_q[c]    <= '0;
				prev_valid_q[c]    <= 1'b0;
				prev_duration_q[c] <= '0;
			end
		end else if (adv && chan_ok) begin
			if (over_hit) begin
				if (oc == '0) begin
					run_start_q[cidx] <= samp;
				end
				run_end_q[cidx]     <= samp;
				under_count_q[cidx] <= '0;
				over_count_q[cidx]  <= (oc == COUNT_MAX) ? oc : oc + 32'd1;
				if (new_peak) begin
					peak_value_q[cidx] <= in_s1.level;
					peak_time_q[cidx]  <= samp;
				end
			end else begin
				under_count_q[cidx] <= uc_inc;
				if (under_done) begin
					if (run_ok) begin
						prev_start_q[cidx]    <= rs;
						prev_duration_q[cidx] <= dur_u;
						prev_valid_q[cidx]    <= 1'b1;
					end
					over_count_q[cidx] <= '0;
					run_start_q[cidx]  <= '0;
					run_end_q[cidx]    <= '0;
					peak_value_q[cidx] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q.event_chan      <= in_s1.chan_id;
			out_data_q.event_start     <= FRAME_W'(rs);
			out_data_q.event_duration  <= FRAME_W'(dur_u);
			out_data_q.event_peak_time <= FRAME_W'(pt);
			out_data_q.event_peak      <= pv;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// an event always shows up in the output register on the next edge
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("event load did not raise out_valid");

	// an over-threshold word never produces an event
	a_no_event_on_over: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && over_hit) |-> !load_out)
		else $error("event produced by an over-threshold word");

	// a held input stage keeps its word
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(in_s1)))
		else $error("input stage changed while stalled");

	// the run of an emitted event is cleared afterward
	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (over_count_q[$past(cidx)] == '0))
		else $error("run not cleared after event");

endmodule
